/* design/twisted_cube_next_hop_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef TWISTED_CUBE_NEXT_HOP_UNIT_ASSERT_SVH
`define TWISTED_CUBE_NEXT_HOP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define TCNH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define TCNH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/tcnh_pkg.sv */
package tcnh_pkg;

   localparam int NODE_BITS     = 16;
   localparam int DIR_BITS      = 4;
   localparam int LOG_SIZE_BITS = 5;
   localparam int STATE_BITS    = 64;

   // Field masks for the prefix parities: even and odd bit positions above bit 1.
   localparam logic [STATE_BITS-1:0] ODD_FIELD_MASK  = 64'h5555555555555554;
   localparam logic [STATE_BITS-1:0] EVEN_FIELD_MASK = 64'haaaaaaaaaaaaaaa8;

   localparam logic CSR_NET_WIDTH      = 1'b0;
   localparam logic CSR_TOPOLOGY_STATE = 1'b1;

   localparam logic CMD_NEIGHBOR = 1'b0;
   localparam logic CMD_NEXT_HOP = 1'b1;

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_LOW   = 2'd1;
   localparam logic [1:0] MODE_BELOW = 2'd2;
   localparam logic [1:0] MODE_ALL   = 2'd3;

   typedef struct packed {
      logic                 command;
      logic [NODE_BITS-1:0] node;
      logic [DIR_BITS-1:0]  direction;
      logic [NODE_BITS-1:0] target;
   } req_type;

   typedef struct packed {
      logic [NODE_BITS-1:0] result_node;
      logic                 error;
   } rsp_type;

   typedef struct packed {
      logic                 err;
      logic [NODE_BITS-1:0] node;
      logic [DIR_BITS-1:0]  dim;
   } dec_type;

   typedef struct packed {
      logic                 err;
      logic [NODE_BITS-1:0] node;
      logic [DIR_BITS-1:0]  dim;
      logic [1:0]           mode;
   } mode_type;

endpackage

/* design/tcnh_decode.sv */
module tcnh_decode #(
   parameter int MAX_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   input  tcnh_pkg::req_type                   up_beat,
   output logic                                up_stall,
   input  logic [tcnh_pkg::LOG_SIZE_BITS-1:0]  net_width,
   output logic                                dn_valid,
   output tcnh_pkg::dec_type                   dn_beat,
   input  logic                                dn_stall
);
   import tcnh_pkg::*;

   logic                 valid_ff, valid_in;
   dec_type              beat_ff, beat_in;
   logic [NODE_BITS:0]   span;
   logic [NODE_BITS-1:0] delta;
   logic [DIR_BITS-1:0]  top_dim;
   logic                 bad_width, node_oob, tgt_oob, dir_oob;

   assign up_stall = valid_ff && dn_stall;

   always_comb begin
      bad_width = (net_width < LOG_SIZE_BITS'(2))
               || (net_width > LOG_SIZE_BITS'(MAX_WIDTH));
      span      = ((NODE_BITS+1)'(1) << net_width) - (NODE_BITS+1)'(1);
      node_oob  = |({1'b0, up_beat.node} & ~span);
      tgt_oob   = |({1'b0, up_beat.target} & ~span);
      dir_oob   = {1'b0, up_beat.direction} >= net_width;
   end

   // Highest differing bit; zero when node equals target.
   always_comb begin
      delta   = up_beat.node ^ up_beat.target;
      top_dim = '0;
      for (int i = 0; i < NODE_BITS; i++) begin
         if (delta[i]) top_dim = DIR_BITS'(i);
      end
   end

   always_comb begin
      valid_in     = up_stall ? valid_ff : up_valid;
      beat_in.node = up_beat.node;
      if (up_beat.command == CMD_NEXT_HOP) begin
         beat_in.err = bad_width || node_oob || tgt_oob;
         beat_in.dim = top_dim;
      end else begin
         beat_in.err = bad_width || node_oob || dir_oob;
         beat_in.dim = up_beat.direction;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

endmodule

/* design/tcnh_mode.sv */
module tcnh_mode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   input  tcnh_pkg::dec_type                   up_beat,
   output logic                                up_stall,
   input  logic [tcnh_pkg::LOG_SIZE_BITS-1:0]  net_width,
   input  logic [tcnh_pkg::STATE_BITS-1:0]     topology_state,
   output logic                                dn_valid,
   output tcnh_pkg::mode_type                  dn_beat,
   input  logic                                dn_stall
);
   import tcnh_pkg::*;

   logic                  valid_ff, valid_in;
   mode_type              beat_ff, beat_in;
   logic [NODE_BITS:0]    node_ext;
   logic                  blk0, has_alt, dim1_mode;
   logic [STATE_BITS-1:0] fmask;
   logic [5:0]            alt_pos;
   logic [1:0]            alt, base, m_gen, c;

   assign up_stall = valid_ff && dn_stall;

   always_comb begin
      c        = topology_state[1:0];
      node_ext = {1'b0, up_beat.node};
      // Low bit of the block index node >> (d+1).
      blk0     = node_ext[LOG_SIZE_BITS'(up_beat.dim) + LOG_SIZE_BITS'(1)];
      fmask    = (STATE_BITS'(1) << {up_beat.dim, 1'b0}) - STATE_BITS'(4);
      has_alt  = (LOG_SIZE_BITS'(up_beat.dim) + LOG_SIZE_BITS'(1)) < net_width;
      alt_pos  = 6'({net_width, 1'b0}) + 6'({up_beat.dim, 1'b0}) - 6'd6;
      alt      = 2'(topology_state >> alt_pos);
      case (c)
         2'b10:   base = MODE_LOW;
         2'b11:   base = MODE_BELOW;
         default: base = MODE_NONE;
      endcase
      m_gen = base
            ^ {^(topology_state & fmask & EVEN_FIELD_MASK),
               ^(topology_state & fmask & ODD_FIELD_MASK)}
            ^ ((blk0 && has_alt) ? alt : 2'b00);
      case (c)
         2'b00:   dim1_mode = 1'b0;
         2'b01:   dim1_mode = blk0;
         2'b10:   dim1_mode = ~blk0;
         default: dim1_mode = 1'b1;
      endcase
   end

   always_comb begin
      valid_in     = up_stall ? valid_ff : up_valid;
      beat_in.err  = up_beat.err;
      beat_in.node = up_beat.node;
      beat_in.dim  = up_beat.dim;
      if (up_beat.dim == DIR_BITS'(0)) begin
         beat_in.mode = MODE_NONE;
      end else if (up_beat.dim == DIR_BITS'(1)) begin
         // Width-2 network twists dimension 1 by state bit 0 only.
         beat_in.mode = (net_width == LOG_SIZE_BITS'(2)) ? {1'b0, topology_state[0]}
                                                         : {1'b0, dim1_mode};
      end else begin
         beat_in.mode = m_gen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

endmodule

/* design/tcnh_flip.sv */
module tcnh_flip (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   input  tcnh_pkg::mode_type up_beat,
   output logic               up_stall,
   output logic               dn_valid,
   output tcnh_pkg::rsp_type  dn_beat,
   input  logic               dn_stall
);
   import tcnh_pkg::*;

   logic                 valid_ff, valid_in;
   rsp_type              beat_ff, beat_in;
   logic [NODE_BITS-1:0] onehot, twist;

   assign up_stall = valid_ff && dn_stall;

   always_comb begin
      onehot = NODE_BITS'(1) << up_beat.dim;
      case (up_beat.mode)
         MODE_NONE:  twist = '0;
         MODE_LOW:   twist = NODE_BITS'(1);
         MODE_BELOW: twist = onehot >> 1;
         MODE_ALL:   twist = onehot - NODE_BITS'(1);
         default:    twist = '0;
      endcase
      valid_in            = up_stall ? valid_ff : up_valid;
      beat_in.error       = up_beat.err;
      beat_in.result_node = up_beat.err ? '0 : (up_beat.node ^ onehot ^ twist);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

endmodule

/* design/twisted_cube_next_hop_unit.sv */
// Twisted hypercube next-hop unit. Each request beat gives either the neighbor of a
// node along one dimension or the first hop toward a target (highest differing bit,
// dimension 0 when node equals target). A result beat passes through three register
// stages (range check and hop dimension, twist mode, flip mask); one request is taken
// every cycle while the result side keeps up, and each stage holds its beat under
// stall. Out-of-range width, node, direction or target gives error with a zero result.
// net_width (index 0) and topology_state (index 1) are written through the csr port,
// which is always ready; the user must write them only while no request is in flight,
// as the block itself does not enforce it.
module twisted_cube_next_hop_unit #(
   parameter int MAX_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  tcnh_pkg::req_type                req_beat,
   output logic                             req_stall,
   output logic                             rsp_valid,
   output tcnh_pkg::rsp_type                rsp_beat,
   input  logic                             rsp_stall,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [tcnh_pkg::STATE_BITS-1:0]  csr_data
);
   import tcnh_pkg::*;

   logic [LOG_SIZE_BITS-1:0] net_width_ff, net_width_in;
   logic [STATE_BITS-1:0]    topology_state_ff, topology_state_in;
   logic                     dec_valid, dec_stall, mode_valid, mode_stall;
   dec_type                  dec_beat;
   mode_type                 mode_beat;

   assign csr_ready = 1'b1;

   always_comb begin
      net_width_in      = net_width_ff;
      topology_state_in = topology_state_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NET_WIDTH:      net_width_in      = csr_data[LOG_SIZE_BITS-1:0];
            CSR_TOPOLOGY_STATE: topology_state_in = csr_data;
            default:            net_width_in      = net_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         net_width_ff      <= LOG_SIZE_BITS'(2);
         topology_state_ff <= '0;
      end else begin
         net_width_ff      <= net_width_in;
         topology_state_ff <= topology_state_in;
      end
   end

   tcnh_decode #(.MAX_WIDTH(MAX_WIDTH)) u_decode (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (req_valid),
      .up_beat   (req_beat),
      .up_stall  (req_stall),
      .net_width (net_width_ff),
      .dn_valid  (dec_valid),
      .dn_beat   (dec_beat),
      .dn_stall  (dec_stall)
   );

   tcnh_mode u_mode (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (dec_valid),
      .up_beat        (dec_beat),
      .up_stall       (dec_stall),
      .net_width      (net_width_ff),
      .topology_state (topology_state_ff),
      .dn_valid       (mode_valid),
      .dn_beat        (mode_beat),
      .dn_stall       (mode_stall)
   );

   tcnh_flip u_flip (
      .clock    (clock),
      .reset    (reset),
      .up_valid (mode_valid),
      .up_beat  (mode_beat),
      .up_stall (mode_stall),
      .dn_valid (rsp_valid),
      .dn_beat  (rsp_beat),
      .dn_stall (rsp_stall)
   );

endmodule

/* design/tcnh_checker.sv */
`include "twisted_cube_next_hop_unit_assert.svh"

module tcnh_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input tcnh_pkg::req_type                req_beat,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input tcnh_pkg::rsp_type                rsp_beat,
   input logic                             rsp_stall,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic                             csr_index,
   input logic [tcnh_pkg::STATE_BITS-1:0]  csr_data
);
   import tcnh_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_valid, req_beat, csr_valid, csr_ready, csr_index, csr_data};

   `TCNH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat))
   `TCNH_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_beat.error, rsp_beat.result_node == '0)
   // Back pressure only ever starts from a stalled result.
   `TCNH_ASSERT_NOW(a_stall_src, clock, reset, req_stall, rsp_valid && rsp_stall)
   `TCNH_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind twisted_cube_next_hop_unit tcnh_checker u_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import tcnh_pkg::*;

   localparam int MAX_WIDTH  = 16;
   localparam int PIPE_DEPTH = 3;
   localparam int QUIET_MAX  = 2000;
   localparam int PHASES     = 9;

   // c1 frame settings held in topology_state[1:0]
   localparam logic [1:0] FRAME_NONE = 2'd0;
   localparam logic [1:0] FRAME_ODD  = 2'd1;
   localparam logic [1:0] FRAME_EVEN = 2'd2;
   localparam logic [1:0] FRAME_ALL  = 2'd3;

   logic              clock;
   logic              reset;
   logic              req_valid;
   req_type           req_beat;
   logic              req_stall;
   logic              rsp_valid;
   rsp_type           rsp_beat;
   logic              rsp_stall;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_index;
   logic [63:0]       csr_data;

   twisted_cube_next_hop_unit #(.MAX_WIDTH(MAX_WIDTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_beat  (req_beat),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   typedef struct {
      logic [4:0]  width;
      logic [63:0] state;
      req_type     beat;
      bit          typed;
      rsp_type     want;
   } plan_row_type;

   plan_row_type plan_q[$];
   rsp_type     route_q[$];
   logic [4:0]  cfg_width;
   logic [63:0] cfg_state;
   bit          idle_on;
   int          stall_left;
   int          quiet;
   int          fail_count;
   int          n_checked;
   int          n_hop;
   int          n_neighbor;
   int          n_err;
   int          n_settings;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ---------------- predictor ----------------

   function automatic logic [1:0] twist_mode(int d, logic [15:0] blk);
      logic [63:0] f;
      logic [63:0] alt;
      logic [1:0]  m;
      int          w;
      w = cfg_width;
      if (d == 1) begin
         case (cfg_state[1:0])
            FRAME_NONE: return MODE_NONE;
            FRAME_ODD:  return {1'b0, blk[0]};
            FRAME_EVEN: return {1'b0, ~blk[0]};
            default:    return MODE_LOW;
         endcase
      end
      case (cfg_state[1:0])
         FRAME_EVEN: m = MODE_LOW;
         FRAME_ALL:  m = MODE_BELOW;
         default:    m = MODE_NONE;
      endcase
      f = cfg_state & ((64'd1 << (2 * d)) - 64'd4);
      m[0] = m[0] ^ (^(f & ODD_FIELD_MASK));
      m[1] = m[1] ^ (^(f & EVEN_FIELD_MASK));
      // alternating field only on odd blocks, and only below the top dimension
      if (blk[0] && (d + 1 < w)) begin
         alt = cfg_state >> (2 * w + 2 * d - 6);
         m = m ^ alt[1:0];
      end
      return m;
   endfunction

   function automatic logic [31:0] mode_flips(int d, logic [1:0] m);
      case (m)
         MODE_NONE:  return 32'd0;
         MODE_LOW:   return 32'd1;
         MODE_BELOW: return 32'd1 << (d - 1);
         default:    return (32'd1 << d) - 32'd1;
      endcase
   endfunction

   function automatic logic [15:0] hop_node(logic [15:0] x, int d);
      logic [31:0] v;
      if (d == 0)
         return x ^ 16'd1;
      if (cfg_width == 5'd2 && d == 1)
         return x ^ 16'd2 ^ {15'd0, cfg_state[0]};
      v = {16'd0, x} ^ (32'd1 << d) ^ mode_flips(d, twist_mode(d, x >> (d + 1)));
      return v[15:0];
   endfunction

   function automatic rsp_type route_result(req_type r);
      rsp_type     o;
      int          w;
      int          d;
      logic [15:0] delta;
      logic [31:0] count;
      w = cfg_width;
      o = '0;
      count = 32'd1 << w;
      if (w < 2 || w > MAX_WIDTH)
         o.error = 1'b1;
      else if ({16'd0, r.node} >= count)
         o.error = 1'b1;
      else if (r.command == CMD_NEIGHBOR) begin
         if (r.direction >= w)
            o.error = 1'b1;
         else
            o.result_node = hop_node(r.node, r.direction);
      end else begin
         if ({16'd0, r.target} >= count)
            o.error = 1'b1;
         else begin
            delta = r.node ^ r.target;
            d = 0;
            for (int b = 0; b < 16; b++)
               if (delta[b]) d = b;
            o.result_node = hop_node(r.node, d);
         end
      end
      return o;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic void plan(logic [4:0] w, logic [63:0] st, logic cmd, logic [15:0] node,
                                logic [3:0] dir, logic [15:0] tgt, bit typed = 1'b0,
                                logic [15:0] want_node = 16'd0, logic want_err = 1'b0);
      plan_row_type row;
      row.width = w;
      row.state = st;
      row.beat.command = cmd;
      row.beat.node = node;
      row.beat.direction = dir;
      row.beat.target = tgt;
      row.typed = typed;
      row.want.result_node = want_node;
      row.want.error = want_err;
      plan_q.push_back(row);
   endfunction

   function automatic req_type make_request();
      req_type     r;
      int          w;
      logic [15:0] top;
      bit          good_w;
      w = cfg_width;
      good_w = (w >= 2 && w <= MAX_WIDTH);
      top = good_w ? 16'((32'd1 << w) - 32'd1) : 16'hFFFF;
      r.command = 1'($urandom_range(0, 1));
      r.node = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, top));
      if (!good_w || $urandom_range(0, 9) == 0)
         r.direction = 4'($urandom);
      else
         r.direction = 4'($urandom_range(0, w - 1));
      case ($urandom_range(0, 9))
         0:       r.target = r.node;
         1:       r.target = 16'($urandom);
         default: r.target = 16'($urandom_range(0, top));
      endcase
      return r;
   endfunction

   task automatic send_req(req_type r, bit typed, rsp_type want);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_beat <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed)
         route_q.push_back(want);
      else
         route_q.push_back(route_result(r));
      if (r.command == CMD_NEIGHBOR) n_neighbor++;
      else n_hop++;
      if (route_q[$].error) n_err++;
      @(negedge clock);
   endtask

   // drops valid, lets the pipe empty, then writes both registers
   task automatic program_unit(logic [63:0] width_word, logic [63:0] st);
      req_valid <= 1'b0;
      while (route_q.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_NET_WIDTH;
      csr_data <= width_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_width = width_word[4:0];
      @(negedge clock);
      csr_index <= CSR_TOPOLOGY_STATE;
      csr_data <= st;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_state = st;
      @(negedge clock);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic note_failure(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected node %h err %b, got node %h err %b",
                  $realtime, what, want.result_node, want.error, got.result_node, got.error);
   endtask

   // ---------------- result side ----------------

   always @(negedge clock) begin
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 7);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else
         rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_checked++;
         if (route_q.size() == 0)
            note_failure("result beat with nothing pending", '0, rsp_beat);
         else begin
            want = route_q.pop_front();
            if (rsp_beat.result_node !== want.result_node || rsp_beat.error !== want.error)
               note_failure("result mismatch", want, rsp_beat);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet <= 0;
      else if (quiet >= QUIET_MAX) begin
         $display("timeout: no beat moved for %0d cycles", QUIET_MAX);
         $display("TEST FAILED");
         $finish;
      end else
         quiet <= quiet + 1;
   end

   // ---------------- main sequence ----------------

   initial begin
      logic [4:0]   w;
      logic [63:0]  st;
      logic [63:0]  width_word;
      int           count;
      plan_row_type row;

      reset = 1'b1;
      req_valid = 1'b0;
      req_beat = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_NET_WIDTH;
      csr_data = '0;
      cfg_width = 5'd2;
      cfg_state = '0;
      idle_on = 1'b1;
      stall_left = 0;
      quiet = 0;
      fail_count = 0;
      n_checked = 0;
      n_hop = 0;
      n_neighbor = 0;
      n_err = 0;
      n_settings = 1;

      // width 2 at reset state
      plan(2, 0, CMD_NEIGHBOR, 16'd0, 4'd0, 16'd0, 1, 16'd1, 0);
      plan(2, 0, CMD_NEIGHBOR, 16'd3, 4'd1, 16'hFFFF, 1, 16'd1, 0);
      plan(2, 0, CMD_NEIGHBOR, 16'd0, 4'd2, 16'd0, 1, 16'd0, 1);   // direction == width
      plan(2, 0, CMD_NEIGHBOR, 16'd4, 4'd0, 16'd0, 1, 16'd0, 1);   // node past the top
      plan(2, 0, CMD_NEXT_HOP, 16'd0, 4'd15, 16'd4, 1, 16'd0, 1);  // target past the top
      plan(2, 0, CMD_NEXT_HOP, 16'd2, 4'd15, 16'd2, 1, 16'd3, 0);  // already there: dim 0
      plan(2, 1, CMD_NEIGHBOR, 16'd0, 4'd1, 16'd0, 1, 16'd3, 0);
      plan(2, 1, CMD_NEXT_HOP, 16'd1, 4'd0, 16'd2);
      // bad widths flag everything
      plan(0, '1, CMD_NEIGHBOR, 16'd0, 4'd0, 16'd0, 1, 16'd0, 1);
      plan(1, '1, CMD_NEXT_HOP, 16'd0, 4'd0, 16'd0, 1, 16'd0, 1);
      plan(17, '1, CMD_NEIGHBOR, 16'd0, 4'd0, 16'd0, 1, 16'd0, 1);
      plan(31, 0, CMD_NEXT_HOP, 16'hFFFF, 4'hF, 16'hFFFF, 1, 16'd0, 1);
      // full width
      plan(16, '1, CMD_NEIGHBOR, 16'hFFFF, 4'd15, 16'd0);
      plan(16, '1, CMD_NEXT_HOP, 16'd0, 4'd0, 16'hFFFF);
      plan(16, '1, CMD_NEXT_HOP, 16'hFFFF, 4'd0, 16'd0);
      plan(16, '1, CMD_NEIGHBOR, 16'h8000, 4'd0, 16'd0, 1, 16'h8001, 0);
      plan(16, '1, CMD_NEIGHBOR, 16'h5555, 4'd1, 16'd0);
      plan(16, 0, CMD_NEXT_HOP, 16'h1234, 4'd0, 16'h1234, 1, 16'h1235, 0);
      plan(16, 0, CMD_NEIGHBOR, 16'hAAAA, 4'd7, 16'd0);
      plan(16, 64'hA5A5_5A5A_0F0F_F0F0, CMD_NEIGHBOR, 16'h0001, 4'd14, 16'd0);
      // width 3
      plan(3, 64'hF, CMD_NEIGHBOR, 16'd7, 4'd2, 16'd0);
      plan(3, 64'hF, CMD_NEXT_HOP, 16'd5, 4'd0, 16'd1);
      plan(3, 64'h2, CMD_NEIGHBOR, 16'd0, 4'd3, 16'd0, 1, 16'd0, 1);
      plan(3, 64'h2, CMD_NEXT_HOP, 16'd8, 4'd0, 16'd0, 1, 16'd0, 1);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan_q[i]) begin
         row = plan_q[i];
         if (row.width != cfg_width || row.state != cfg_state)
            program_unit({59'd0, row.width}, row.state);
         send_req(row.beat, row.typed, row.want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: w = 5'd2;
            1: w = 5'd16;
            2: w = 5'd16;
            3: w = $urandom_range(0, 1) ? 5'($urandom_range(0, 1)) : 5'($urandom_range(17, 31));
            4: w = 5'd3;
            default: w = 5'($urandom_range(2, MAX_WIDTH));
         endcase
         case (ph)
            1: st = '1;
            2: st = '0;
            default: st = {$urandom, $urandom};
         endcase
         // upper bits of the width word are don't-care
         width_word = {$urandom, $urandom};
         width_word[4:0] = w;
         idle_on = (ph != PHASES - 1);
         program_unit(width_word, st);
         count = (w < 2 || w > MAX_WIDTH) ? 40 : 195;
         repeat (count) send_req(make_request(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (route_q.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(negedge clock);

      $display("checked %0d result beats over %0d register settings", n_checked, n_settings);
      $display("%0d next-hop and %0d neighbor requests, %0d with error expected",
               n_hop, n_neighbor, n_err);
      if (fail_count == 0 && route_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/tcnh_pkg.sv
design/tcnh_decode.sv
design/tcnh_mode.sv
design/tcnh_flip.sv
design/twisted_cube_next_hop_unit.sv
design/tcnh_checker.sv
tb/tb_top.sv
